FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, held off while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: hdl/jrsm_pkg.sv
// Types, codes and constants of the join retry state machine.
package jrsm_pkg;

    localparam int DELAY_BITS  = 20;
    localparam int TALLY_BITS  = 8;
    localparam int DC_BITS     = 5;
    localparam int DOUBLE_MAX  = 31;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [TALLY_BITS-1:0] TALLY_MAX = 8'hFF;

    // Link state codes as they appear on the result beat
    localparam logic [2:0] LS_UNPROV  = 3'd0;
    localparam logic [2:0] LS_JOINING = 3'd1;
    localparam logic [2:0] LS_PORTAL  = 3'd2;
    localparam logic [2:0] LS_RETRY   = 3'd3;
    localparam logic [2:0] LS_ONLINE  = 3'd4;

    typedef enum logic [4:0] {
        LINK_UNPROV  = 5'b00001,
        LINK_JOINING = 5'b00010,
        LINK_PORTAL  = 5'b00100,
        LINK_RETRY   = 5'b01000,
        LINK_ONLINE  = 5'b10000
    } t_link_fsm;

    typedef enum logic [2:0] {
        EV_RESET   = 3'd0,
        EV_BOOT    = 3'd1,
        EV_JOIN    = 3'd2,
        EV_RETRY   = 3'd3,
        EV_SAVED   = 3'd4,
        EV_LOST    = 3'd5
    } t_event;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_FAIL  = 2'd0,
        CFG_BASE      = 2'd1,
        CFG_MAX_DELAY = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [2:0] mode;
        logic       event_flag;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]            link_state;
        logic [TALLY_BITS-1:0] failure_count;
        logic [DELAY_BITS-1:0] retry_delay_ms;
    } t_out_beat;

    // Link state with its failure bookkeeping
    typedef struct packed {
        t_link_fsm             link;
        logic [TALLY_BITS-1:0] tally;
        logic [DC_BITS-1:0]    dbl;
        logic                  capped;
    } t_lstate;

    function automatic logic [2:0] encode_link(input t_link_fsm link);
        logic [2:0] code;
        case (link)
            LINK_UNPROV:  code = LS_UNPROV;
            LINK_JOINING: code = LS_JOINING;
            LINK_PORTAL:  code = LS_PORTAL;
            LINK_RETRY:   code = LS_RETRY;
            LINK_ONLINE:  code = LS_ONLINE;
            default:      code = LS_UNPROV;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/join_retry_state_machine_unit.sv
// Top level of the join retry state machine with exponential backoff.
//
// One event beat is taken per clock while the input is not stalled, and one result
// beat comes out for each, in order. A beat passes three registers: the input
// register, a state-update stage in which the link state, failure tally and
// doubling count are rewritten, and the result register, where the retry delay
// (base shifted by the doubling count, clamped to the ceiling) is formed.
// Sustained rate is one beat per cycle while the output is not stalled. The input
// stalls only when all three stages hold beats and the output is stalled.
// Configuration writes take effect at once and should be made while no beat is
// in flight.
`include "assert_macros.svh"

module join_retry_state_machine_unit
    import jrsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_beat                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_beat               o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DELAY_BITS-1:0]   i_cfg_data
);

    logic [TALLY_BITS-1:0] r_max_fail;
    logic [DELAY_BITS-1:0] r_base;
    logic [DELAY_BITS-1:0] r_max_delay;

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_s1_valid;
    t_lstate   r_state;
    t_lstate   n_state;
    logic      r_out_valid;
    t_out_beat r_out;

    logic                  rdy_out;
    logic                  rdy_s1;
    logic                  rdy_in;
    logic                  mv_in;
    logic                  mv_s1;
    logic                  mv_out;
    logic [DELAY_BITS-1:0] delay;

    assign rdy_out = !r_out_valid || !i_out_stall;
    assign rdy_s1  = !r_s1_valid || rdy_out;
    assign rdy_in  = !r_in_valid || rdy_s1;

    assign mv_in  = i_in_valid && rdy_in;
    assign mv_s1  = r_in_valid && rdy_s1;
    assign mv_out = r_s1_valid && rdy_out;

    assign o_in_stall  = !rdy_in;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    jrsm_next u_next (
        .i_beat     (r_in),
        .i_cur      (r_state),
        .i_max_fail (r_max_fail),
        .o_next     (n_state)
    );

    jrsm_delay u_delay (
        .i_dbl    (r_state.dbl),
        .i_capped (r_state.capped),
        .i_base   (r_base),
        .i_max    (r_max_delay),
        .o_delay  (delay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fail  <= TALLY_BITS'(5);
            r_base      <= DELAY_BITS'(1000);
            r_max_delay <= DELAY_BITS'(60000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_FAIL:  r_max_fail  <= i_cfg_data[TALLY_BITS-1:0];
                CFG_BASE:      r_base      <= i_cfg_data;
                CFG_MAX_DELAY: r_max_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state.link   <= LINK_UNPROV;
            r_state.tally  <= '0;
            r_state.dbl    <= '0;
            r_state.capped <= 1'b0;
        end else begin
            if (rdy_in) r_in_valid <= i_in_valid;
            if (rdy_s1) r_s1_valid <= r_in_valid;
            if (rdy_out) r_out_valid <= r_s1_valid;
            // Stage one holds no copy: the state register is its payload
            if (mv_s1) r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_in) r_in <= i_in_data;
        if (mv_out) begin
            r_out.link_state     <= encode_link(r_state.link);
            r_out.failure_count  <= r_state.tally;
            r_out.retry_delay_ms <= delay;
        end
    end

    `ASSERT_CLK(a_zero_tally, i_clk, i_rst_n,
        (r_state.tally == '0) |-> ((r_state.dbl == '0) && !r_state.capped))
    `ASSERT_CLK(a_capped, i_clk, i_rst_n,
        r_state.capped |-> ((r_state.dbl == DC_BITS'(DOUBLE_MAX))
            && (r_state.tally > TALLY_BITS'(DOUBLE_MAX + 1))))
    `ASSERT_CLK(a_online_clean, i_clk, i_rst_n,
        (r_state.link == LINK_ONLINE) |-> (r_state.tally == '0))
    `ASSERT_CLK(a_stall_full, i_clk, i_rst_n,
        o_in_stall |-> (r_in_valid && r_s1_valid && r_out_valid))

endmodule

FILE: hdl/jrsm_next.sv
// Next link state and failure bookkeeping for one event beat.
module jrsm_next
    import jrsm_pkg::*;
(
    input  t_in_beat              i_beat,
    input  t_lstate               i_cur,
    input  logic [TALLY_BITS-1:0] i_max_fail,
    output t_lstate               o_next
);

    // Derive doubling count and cap flag from a tally
    function automatic t_lstate with_tally(input t_lstate s, input logic [TALLY_BITS-1:0] t);
        t_lstate r;
        r = s;
        r.tally = t;
        if (t == '0) begin
            r.dbl    = '0;
            r.capped = 1'b0;
        end else if ((t - 1'b1) > TALLY_BITS'(DOUBLE_MAX)) begin
            r.dbl    = DC_BITS'(DOUBLE_MAX);
            r.capped = 1'b1;
        end else begin
            r.dbl    = DC_BITS'(t - 1'b1);
            r.capped = 1'b0;
        end
        return r;
    endfunction

    logic [TALLY_BITS-1:0] inc_tally;

    assign inc_tally = (i_cur.tally != TALLY_MAX) ? i_cur.tally + 1'b1 : i_cur.tally;

    always_comb begin
        o_next = i_cur;
        case (t_event'(i_beat.mode))
            EV_RESET: begin
                o_next      = with_tally(i_cur, '0);
                o_next.link = LINK_UNPROV;
            end
            EV_BOOT: begin
                o_next      = with_tally(i_cur, '0);
                o_next.link = i_beat.event_flag ? LINK_JOINING : LINK_PORTAL;
            end
            EV_JOIN: begin
                if (i_beat.event_flag) begin
                    o_next      = with_tally(i_cur, '0);
                    o_next.link = LINK_ONLINE;
                end else begin
                    o_next      = with_tally(i_cur, inc_tally);
                    o_next.link = (inc_tally >= i_max_fail) ? LINK_PORTAL : LINK_RETRY;
                end
            end
            EV_RETRY: begin
                if (i_cur.link == LINK_RETRY) o_next.link = LINK_JOINING;
            end
            EV_SAVED: begin
                if (i_beat.event_flag) begin
                    o_next      = with_tally(i_cur, '0);
                    o_next.link = LINK_JOINING;
                end else begin
                    o_next.link = LINK_PORTAL;
                end
            end
            EV_LOST: begin
                if (i_cur.link == LINK_ONLINE) o_next.link = LINK_JOINING;
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

endmodule

FILE: hdl/jrsm_delay.sv
// Retry delay: base shifted by the doubling count, clamped to the ceiling.
module jrsm_delay
    import jrsm_pkg::*;
(
    input  logic [DC_BITS-1:0]    i_dbl,
    input  logic                  i_capped,
    input  logic [DELAY_BITS-1:0] i_base,
    input  logic [DELAY_BITS-1:0] i_max,
    output logic [DELAY_BITS-1:0] o_delay
);

    localparam int SH_BITS = DELAY_BITS + DOUBLE_MAX;

    logic [SH_BITS-1:0] shifted;
    logic [SH_BITS-1:0] ceiling;

    // Shift wide enough that no bit of the base is lost before the compare
    assign shifted = {{DOUBLE_MAX{1'b0}}, i_base} << i_dbl;
    assign ceiling = {{DOUBLE_MAX{1'b0}}, i_max};

    always_comb begin
        if (i_capped || (shifted > ceiling)) begin
            o_delay = i_max;
        end else begin
            o_delay = shifted[DELAY_BITS-1:0];
        end
    end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the join retry state machine with retry backoff.
module tb_top;
    import jrsm_pkg::*;

    localparam logic [2:0] EV_SPARE_6 = 3'd6;
    localparam logic [2:0] EV_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD_CYCLES = 120;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    t_in_beat                in_data = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    t_out_beat               out_data;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [DELAY_BITS-1:0]   cfg_data = '0;

    // Link state and registers as this side of the bench tracks them
    logic [2:0]            lk_state;
    logic [TALLY_BITS-1:0] lk_tally;
    logic [DC_BITS-1:0]    lk_dbl;
    logic                  lk_capped;
    logic [TALLY_BITS-1:0] cfg_max_fail;
    logic [DELAY_BITS-1:0] cfg_base;
    logic [DELAY_BITS-1:0] cfg_ceiling;

    t_out_beat pending_results[$];
    int        items_sent = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;
    bit        hold_req = 1'b0;
    bit        hold_ack = 1'b0;
    bit        failed = 1'b0;

    join_retry_state_machine_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void load_tally(input logic [TALLY_BITS-1:0] t);
        int above_first;
        above_first = int'(t) - 1;
        lk_tally = t;
        if (t == 0) begin
            lk_dbl = '0;
            lk_capped = 1'b0;
        end else if (above_first > DOUBLE_MAX) begin
            lk_dbl = DC_BITS'(DOUBLE_MAX);
            lk_capped = 1'b1;
        end else begin
            lk_dbl = DC_BITS'(above_first);
            lk_capped = 1'b0;
        end
    endfunction

    function automatic logic [DELAY_BITS-1:0] backoff_delay();
        logic [63:0] d;
        if (lk_capped) return cfg_ceiling;
        d = 64'(cfg_base) << lk_dbl;
        if (d > 64'(cfg_ceiling)) d = 64'(cfg_ceiling);
        return d[DELAY_BITS-1:0];
    endfunction

    function automatic t_out_beat advance_link(input t_in_beat b);
        t_out_beat r;
        case (b.mode)
            EV_RESET: begin
                lk_state = LS_UNPROV;
                load_tally('0);
            end
            EV_BOOT: begin
                load_tally('0);
                lk_state = b.event_flag ? LS_JOINING : LS_PORTAL;
            end
            EV_JOIN: begin
                if (b.event_flag) begin
                    load_tally('0);
                    lk_state = LS_ONLINE;
                end else begin
                    if (lk_tally != TALLY_MAX) load_tally(lk_tally + 1'b1);
                    lk_state = (lk_tally >= cfg_max_fail) ? LS_PORTAL : LS_RETRY;
                end
            end
            EV_RETRY: begin
                if (lk_state == LS_RETRY) lk_state = LS_JOINING;
            end
            EV_SAVED: begin
                if (b.event_flag) begin
                    load_tally('0);
                    lk_state = LS_JOINING;
                end else begin
                    lk_state = LS_PORTAL;
                end
            end
            EV_LOST: begin
                if (lk_state == LS_ONLINE) lk_state = LS_JOINING;
            end
            default: ;
        endcase
        r.link_state     = lk_state;
        r.failure_count  = lk_tally;
        r.retry_delay_ms = backoff_delay();
        return r;
    endfunction

    task automatic send_event(input logic [2:0] mode, input logic flag);
        t_in_beat b;
        b.mode = mode;
        b.event_flag = flag;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(advance_link(b));
        items_sent++;
    endtask

    // Drop valid and wait out every beat still in flight
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [DELAY_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_FAIL:  cfg_max_fail = val[TALLY_BITS-1:0];
            CFG_BASE:      cfg_base = val;
            CFG_MAX_DELAY: cfg_ceiling = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input int max_fail, input int base, input int ceiling);
        drain();
        write_reg(CFG_MAX_FAIL, DELAY_BITS'(max_fail));
        write_reg(CFG_BASE, DELAY_BITS'(base));
        write_reg(CFG_MAX_DELAY, DELAY_BITS'(ceiling));
    endtask

    function automatic int pick_delay();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 1000000;
            3: return (1 << DELAY_BITS) - 1;
            4, 5: return $urandom_range(1, 1000000);
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    task automatic apply_random_settings();
        int mf;
        int base;
        int ceiling;
        case ($urandom_range(5))
            0: mf = 0;
            1: mf = 255;
            2: mf = $urandom_range(0, 255);
            default: mf = $urandom_range(1, 10);
        endcase
        base = pick_delay();
        ceiling = ($urandom_range(3) == 0) ? pick_delay() : $urandom_range(1, 1000000);
        write_all(mf, base, ceiling);
        if ($urandom_range(1) == 1)
            write_reg(CFG_SPARE, DELAY_BITS'($urandom_range(0, (1 << DELAY_BITS) - 1)));
    endtask

    // Failed joins, each mostly followed by a retry-elapsed beat
    task automatic run_failure_burst(input int n);
        for (int k = 0; k < n; k++) begin
            send_event(EV_JOIN, 1'b0);
            case ($urandom_range(9))
                0: send_event(EV_LOST, 1'($urandom_range(1)));
                1: send_event($urandom_range(1) ? EV_SPARE_6 : EV_SPARE_7,
                              1'($urandom_range(1)));
                2: ;
                default: send_event(EV_RETRY, 1'($urandom_range(1)));
            endcase
        end
    endtask

    task automatic test_directed_events();
        send_event(EV_RESET, 1'b0);
        send_event(EV_RETRY, 1'b0);
        send_event(EV_LOST, 1'b1);
        send_event(EV_BOOT, 1'b0);
        send_event(EV_SAVED, 1'b0);
        send_event(EV_SAVED, 1'b1);
        send_event(EV_JOIN, 1'b0);
        send_event(EV_RETRY, 1'b1);
        send_event(EV_JOIN, 1'b0);
        send_event(EV_JOIN, 1'b0);
        send_event(EV_JOIN, 1'b1);
        send_event(EV_LOST, 1'b0);
        send_event(EV_SPARE_6, 1'b1);
        send_event(EV_SPARE_7, 1'b0);
        send_event(EV_BOOT, 1'b1);
        for (int k = 0; k < 6; k++) send_event(EV_JOIN, 1'b0);
        send_event(EV_RETRY, 1'b0);
        send_event(EV_RESET, 1'b1);
    endtask

    task automatic test_register_extremes();
        write_all(0, 1000, 60000);
        send_event(EV_BOOT, 1'b1);
        run_failure_burst(2);
        write_all(255, 1, 1000000);
        send_event(EV_BOOT, 1'b1);
        run_failure_burst(24);
        write_all(3, 1000000, 1000000);
        run_failure_burst(3);
        write_all(2, 0, 60000);
        send_event(EV_BOOT, 1'b1);
        run_failure_burst(3);
        write_all(2, 1000, 0);
        run_failure_burst(2);
        write_all(4, 50000, 1);
        send_event(EV_SAVED, 1'b1);
        run_failure_burst(3);
        write_all(1, 1, 1);
        write_reg(CFG_SPARE, '1);
        run_failure_burst(2);
        write_all(5, (1 << DELAY_BITS) - 1, (1 << DELAY_BITS) - 1);
        send_event(EV_BOOT, 1'b1);
        run_failure_burst(3);
    endtask

    task automatic test_random_traffic(input int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                send_event($urandom_range(3) == 0 ? EV_SAVED : EV_BOOT, $urandom_range(7) != 0);
                repeat ($urandom_range(1, ($urandom_range(5) == 0) ? 40 : 8)) begin
                    if ($urandom_range(9) == 0) begin
                        send_event(EV_JOIN, 1'b1);
                        if ($urandom_range(1)) send_event(EV_LOST, 1'($urandom_range(1)));
                    end else begin
                        run_failure_burst(1);
                    end
                    if ($urandom_range(19) == 0) send_event(EV_SAVED, 1'($urandom_range(1)));
                end
            end else begin
                send_event(3'($urandom_range(7)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_failure_saturation();
        write_all(255, $urandom_range(1, 100), 1000000);
        send_event(EV_BOOT, 1'b1);
        for (int k = 0; k < 258; k++) send_event(EV_JOIN, 1'b0);
        // tally pinned at its ceiling: drop to the portal and recover
        write_all($urandom_range(0, 254), $urandom_range(1, 1000), $urandom_range(1, 1000000));
        run_failure_burst(2);
        send_event(EV_SAVED, 1'b1);
    endtask

    // Hold the result side while beats keep arriving so the input backs up
    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = !hold_req;
        send_event(EV_BOOT, 1'b1);
        run_failure_burst(8);
        test_random_traffic(5);
    endtask

    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expected result waiting");
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (out_data.link_state !== want.link_state) begin
                    $error("link_state: expected %0d, got %0d",
                           want.link_state, out_data.link_state);
                    failed = 1'b1;
                end
                if (out_data.failure_count !== want.failure_count) begin
                    $error("failure_count: expected %0d, got %0d",
                           want.failure_count, out_data.failure_count);
                    failed = 1'b1;
                end
                if (out_data.retry_delay_ms !== want.retry_delay_ms) begin
                    $error("retry_delay_ms: expected %0d, got %0d",
                           want.retry_delay_ms, out_data.retry_delay_ms);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        lk_state = LS_UNPROV;
        load_tally('0);
        cfg_max_fail = 8'd5;
        cfg_base = 20'd1000;
        cfg_ceiling = 20'd60000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_events();
        test_register_extremes();

        drain();
        send_idle_pct = 0;
        stall_pct = 0;
        apply_random_settings();
        test_random_traffic(8);

        drain();
        send_idle_pct = 72;
        stall_pct = 0;
        apply_random_settings();
        test_random_traffic(8);

        drain();
        send_idle_pct = 0;
        stall_pct = 72;
        apply_random_settings();
        test_random_traffic(8);

        drain();
        send_idle_pct = 16;
        stall_pct = 16;
        apply_random_settings();
        test_random_traffic(8);

        test_failure_saturation();
        test_backpressure();

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (!failed) begin
            $display("join_retry_state_machine_unit regression: pass");
        end else begin
            $display("join_retry_state_machine_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("join_retry_state_machine_unit regression: fail");
        $finish;
    end

endmodule
